/* rtl/srcu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srcu_pkg
// Status and instruction-kind codes shared by the reconvergence unit.
// ----------------------------------------------------------------------------
package srcu_pkg;

    typedef logic [2:0] t_status;
    typedef logic [1:0] t_kind;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_OPND  = 3'd1;
    localparam t_status ST_BUSY      = 3'd2;
    localparam t_status ST_MISMATCH  = 3'd3;
    localparam t_status ST_MISSING   = 3'd4;
    localparam t_status ST_NO_OUTER  = 3'd5;
    localparam t_status ST_DIVERGE   = 3'd6;
    localparam t_status ST_FULL      = 3'd7;

    localparam t_kind KIND_BRANCH = 2'd0;
    localparam t_kind KIND_OPEN   = 2'd1;
    localparam t_kind KIND_SYNC   = 2'd2;
    localparam t_kind KIND_BREAK  = 2'd3;

endpackage
`default_nettype wire

/* rtl/srcu_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srcu_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module srcu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/simt_reconvergence_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// simt_reconvergence_unit
// Divergence and reconvergence control for one warp: active mask, barrier
// frames, pending and escaped path lists in RAM, and a stack of open regions.
// ----------------------------------------------------------------------------
//  channel     direction  word
//  s_axis      in         tuser {reliable, kind}; tdata {guard, pc, target, barrier}
//  m_axis      out        tdata {active_out, next_pc, status}
//
//  An instruction passes an accept step and a decide step, then a RAM read
//  step when a pending path is resumed, or, when a region hands its n escaped
//  paths to the enclosing one, one RAM read and one write per path, then a finish.
//  Reset is synchronous and clears all frames; path RAMs are not cleared.
//  The next word is accepted while a result waits on m_axis; the decide step
//  stalls until the output register is free.
module simt_reconvergence_unit
    import srcu_pkg::*;
#(
    parameter int WARP_LANES        = 32,
    parameter int BARRIER_REGS      = 16,
    parameter int PATHS_PER_FRAME   = 32,
    parameter int INSTRUCTION_BYTES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [3:0] barrier_index, [35:4] target, [67:36] instr_pc,
    // [99:68] guard_mask, [103:100] zero
    input  wire logic [103:0] i_s_axis_tdata,
    // [1:0] kind, [2] reliable
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [2:0] status, [34:3] next_pc, [66:35] active_out, [71:67] zero
    output logic      [71:0]  o_m_axis_tdata
);

    localparam int BW = $clog2(BARRIER_REGS);
    localparam int DW = $clog2(BARRIER_REGS + 1);
    localparam int PW = $clog2(PATHS_PER_FRAME);
    localparam int CW = $clog2(PATHS_PER_FRAME + 1);
    localparam int RDEPTH = BARRIER_REGS * PATHS_PER_FRAME;
    localparam int AW = $clog2(RDEPTH);
    localparam int MW = 32 + WARP_LANES;
    localparam logic [31:0] LANE_MASK = 32'((64'd1 << WARP_LANES) - 64'd1);
    localparam logic [31:0] IBYTES = 32'(INSTRUCTION_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RES  = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [1:0] OP_DONE   = 2'd0;
    localparam logic [1:0] OP_RESUME = 2'd1;
    localparam logic [1:0] OP_MOVE   = 2'd2;

    function automatic logic [1023:0] mod_table();
        logic [1023:0] t;
        t = '0;
        for (int k = 0; k < 256; k++) begin
            t[k*4 +: 4] = 4'(k % INSTRUCTION_BYTES);
        end
        return t;
    endfunction

    // Remainder of {partial remainder, nibble} by the instruction size.
    localparam logic [1023:0] MOD_TAB = mod_table();

    function automatic logic misaligned(input logic [31:0] v);
        logic [3:0] rem;
        rem = 4'd0;
        for (int k = 7; k >= 0; k--) begin
            rem = MOD_TAB[{rem, v[k*4 +: 4], 2'b00} +: 4];
        end
        return rem != 4'd0;
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] f,
                                                input logic [CW-1:0] s);
        return AW'(32'(f) * PATHS_PER_FRAME + 32'(s));
    endfunction

    logic [2:0]    r_state;
    logic [1:0]    r_kind;
    logic          r_rel;
    logic [3:0]    r_idx;
    logic [31:0]   r_tgt, r_ipc, r_guard;

    logic [31:0]   r_active, n_active;
    logic          r_valid [BARRIER_REGS], n_valid [BARRIER_REGS];
    logic          r_frel  [BARRIER_REGS], n_frel  [BARRIER_REGS];
    logic [31:0]   r_ftgt  [BARRIER_REGS], n_ftgt  [BARRIER_REGS];
    logic [31:0]   r_fpart [BARRIER_REGS], n_fpart [BARRIER_REGS];
    logic [31:0]   r_farr  [BARRIER_REGS], n_farr  [BARRIER_REGS];
    logic [CW-1:0] r_pcnt  [BARRIER_REGS], n_pcnt  [BARRIER_REGS];
    logic [CW-1:0] r_ecnt  [BARRIER_REGS], n_ecnt  [BARRIER_REGS];
    logic [BW-1:0] r_stack [BARRIER_REGS], n_stack [BARRIER_REGS];
    logic [DW-1:0] r_depth, n_depth;

    logic          r_ovalid;
    logic [71:0]   r_odata;
    logic [31:0]   r_res_pc;
    logic [BW-1:0] r_mv_src, r_mv_dst;
    logic [CW-1:0] r_mv_base, r_mv_cnt, r_mi;

    logic          out_free;
    logic          out_load;
    logic          dec_go;
    logic [1:0]    c_op;
    t_status       c_st;
    logic [31:0]   c_pc;
    logic          c_pw_en, c_ew_en;
    logic [AW-1:0] c_pw_addr, c_ew_addr, c_rd_addr;
    logic [MW-1:0] c_pw_data, c_ew_data;
    logic [BW-1:0] c_mv_src, c_mv_dst;
    logic [CW-1:0] c_mv_base, c_mv_cnt;

    logic          pw_en;
    logic [AW-1:0] pw_addr;
    logic [MW-1:0] pw_data, p_rdata, e_rdata;
    logic [AW-1:0] e_raddr;

    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign dec_go          = (r_state == S_DEC) && out_free;
    assign out_load        = (dec_go && (c_op == OP_DONE)) ||
                             (((r_state == S_RES) || (r_state == S_FIN)) && out_free);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Decide step: one instruction's checks and all frame updates.
    always_comb begin
        logic [31:0]   act, seq, taking, part;
        logic [BW-1:0] b, top, outer;
        logic          tgt_bad, idx_ok, top_ok;
        logic [CW:0]   need, osum;

        n_active = r_active;
        n_valid  = r_valid;
        n_frel   = r_frel;
        n_ftgt   = r_ftgt;
        n_fpart  = r_fpart;
        n_farr   = r_farr;
        n_pcnt   = r_pcnt;
        n_ecnt   = r_ecnt;
        n_stack  = r_stack;
        n_depth  = r_depth;
        c_op      = OP_DONE;
        c_st      = ST_OK;
        c_pc      = r_ipc;
        c_pw_en   = 1'b0;
        c_ew_en   = 1'b0;
        c_pw_addr = '0;
        c_ew_addr = '0;
        c_rd_addr = '0;
        c_pw_data = '0;
        c_ew_data = '0;
        c_mv_src  = '0;
        c_mv_dst  = '0;
        c_mv_base = '0;
        c_mv_cnt  = '0;

        act     = r_active;
        seq     = r_ipc + IBYTES;
        taking  = act & r_guard;
        b       = r_idx[BW-1:0];
        top     = r_stack[BW'(r_depth - DW'(1))];
        outer   = r_stack[BW'(r_depth - DW'(2))];
        tgt_bad = misaligned(r_tgt);
        idx_ok  = 32'(r_idx) < BARRIER_REGS;
        top_ok  = (r_depth != '0) && (4'(top) == r_idx);
        part    = r_fpart[b] & ~taking;
        need    = '0;
        osum    = '0;

        if (r_kind == KIND_BRANCH) begin
            if (tgt_bad) begin
                c_st = ST_BAD_OPND;
            end else if (taking == '0) begin
                c_pc = seq;
            end else if (taking == act) begin
                c_pc = r_tgt;
            end else if (r_depth == '0) begin
                c_st = ST_DIVERGE;
            end else if (!r_valid[top]) begin
                c_st = ST_MISMATCH;
            end else if (32'(r_pcnt[top]) >= PATHS_PER_FRAME) begin
                c_st = ST_FULL;
            end else begin
                c_pw_en      = 1'b1;
                c_pw_addr    = slot_addr(top, r_pcnt[top]);
                c_pw_data    = {r_tgt, taking[WARP_LANES-1:0]};
                n_pcnt[top]  = r_pcnt[top] + CW'(1);
                n_active     = act & ~taking;
                c_pc         = seq;
            end
        end else if (!idx_ok) begin
            c_st = ST_BAD_OPND;
        end else if (r_kind == KIND_OPEN) begin
            if (tgt_bad) begin
                c_st = ST_BAD_OPND;
            end else if (r_valid[b]) begin
                c_st = ST_BUSY;
            end else if (32'(r_depth) >= BARRIER_REGS) begin
                c_st = ST_FULL;
            end else begin
                n_valid[b] = 1'b1;
                n_frel[b]  = r_rel;
                n_ftgt[b]  = r_tgt;
                n_fpart[b] = act;
                n_farr[b]  = '0;
                n_pcnt[b]  = '0;
                n_ecnt[b]  = '0;
                n_stack[BW'(r_depth)] = b;
                n_depth    = r_depth + DW'(1);
                c_pc       = seq;
            end
        end else if (!top_ok || !r_valid[b] || (r_frel[b] != r_rel)) begin
            c_st = ST_MISMATCH;
        end else if (r_kind == KIND_SYNC) begin
            osum = (CW+1)'(r_pcnt[outer]) + (CW+1)'(r_ecnt[b]);
            if (r_pcnt[b] != '0) begin
                n_farr[b] = r_farr[b] | act;
                n_pcnt[b] = r_pcnt[b] - CW'(1);
                c_rd_addr = slot_addr(b, r_pcnt[b] - CW'(1));
                c_op      = OP_RESUME;
            end else if ((r_farr[b] | act) != r_fpart[b]) begin
                c_st = ST_MISSING;
            end else if (r_ecnt[b] != '0 && r_depth < DW'(2)) begin
                c_st = ST_NO_OUTER;
            end else if (r_ecnt[b] != '0 && 32'(osum) > PATHS_PER_FRAME) begin
                c_st = ST_FULL;
            end else begin
                if (r_ecnt[b] != '0) begin
                    c_op          = OP_MOVE;
                    c_mv_src      = b;
                    c_mv_dst      = outer;
                    c_mv_base     = r_pcnt[outer];
                    c_mv_cnt      = r_ecnt[b];
                    n_pcnt[outer] = CW'(osum);
                end
                n_active   = r_fpart[b];
                c_pc       = r_ftgt[b];
                n_valid[b] = 1'b0;
                n_frel[b]  = 1'b0;
                n_ftgt[b]  = '0;
                n_fpart[b] = '0;
                n_farr[b]  = '0;
                n_pcnt[b]  = '0;
                n_ecnt[b]  = '0;
                n_depth    = r_depth - DW'(1);
            end
        end else begin
            need = (CW+1)'(r_ecnt[b]) + (CW+1)'(part != '0);
            osum = (CW+1)'(r_pcnt[outer]) + need;
            if (taking == '0) begin
                c_pc = seq;
            end else if (taking != act) begin
                if (32'(r_ecnt[b]) >= PATHS_PER_FRAME) begin
                    c_st = ST_FULL;
                end else begin
                    c_ew_en    = 1'b1;
                    c_ew_addr  = slot_addr(b, r_ecnt[b]);
                    c_ew_data  = {seq, taking[WARP_LANES-1:0]};
                    n_ecnt[b]  = r_ecnt[b] + CW'(1);
                    n_fpart[b] = part;
                    n_active   = act & ~taking;
                    c_pc       = seq;
                end
            end else if (r_depth < DW'(2)) begin
                c_st = ST_NO_OUTER;
            end else if (r_pcnt[b] != '0) begin
                if (32'(r_ecnt[b]) >= PATHS_PER_FRAME) begin
                    c_st = ST_FULL;
                end else begin
                    c_ew_en    = 1'b1;
                    c_ew_addr  = slot_addr(b, r_ecnt[b]);
                    c_ew_data  = {seq, taking[WARP_LANES-1:0]};
                    n_ecnt[b]  = r_ecnt[b] + CW'(1);
                    n_fpart[b] = part;
                    n_pcnt[b]  = r_pcnt[b] - CW'(1);
                    c_rd_addr  = slot_addr(b, r_pcnt[b] - CW'(1));
                    c_op       = OP_RESUME;
                end
            end else if (r_farr[b] != part) begin
                c_st = ST_MISSING;
            end else if (32'(osum) > PATHS_PER_FRAME) begin
                c_st = ST_FULL;
            end else begin
                // The remaining lanes wait at the region target in the outer frame.
                if (part != '0) begin
                    c_pw_en   = 1'b1;
                    c_pw_addr = slot_addr(outer, r_pcnt[outer]);
                    c_pw_data = {r_ftgt[b], part[WARP_LANES-1:0]};
                end
                if (r_ecnt[b] != '0) begin
                    c_op      = OP_MOVE;
                    c_mv_src  = b;
                    c_mv_dst  = outer;
                    c_mv_base = r_pcnt[outer] + CW'(part != '0);
                    c_mv_cnt  = r_ecnt[b];
                end
                n_pcnt[outer] = CW'(osum);
                c_pc       = seq;
                n_valid[b] = 1'b0;
                n_frel[b]  = 1'b0;
                n_ftgt[b]  = '0;
                n_fpart[b] = '0;
                n_farr[b]  = '0;
                n_pcnt[b]  = '0;
                n_ecnt[b]  = '0;
                n_depth    = r_depth - DW'(1);
            end
        end
    end

    // Pending RAM write: a push from the decide step, or a moved escaped path.
    always_comb begin
        if (r_state == S_MWR) begin
            pw_en   = 1'b1;
            pw_addr = slot_addr(r_mv_dst, r_mv_base + r_mi);
            pw_data = e_rdata;
        end else begin
            pw_en   = dec_go && c_pw_en;
            pw_addr = c_pw_addr;
            pw_data = c_pw_data;
        end
    end

    assign e_raddr = slot_addr(r_mv_src, r_mi);

    srcu_ram #(.WIDTH(MW), .DEPTH(RDEPTH)) u_pending (
        .i_clk   (i_clk),
        .i_we    (pw_en),
        .i_waddr (pw_addr),
        .i_wdata (pw_data),
        .i_re    (dec_go && (c_op == OP_RESUME)),
        .i_raddr (c_rd_addr),
        .o_rdata (p_rdata)
    );

    srcu_ram #(.WIDTH(MW), .DEPTH(RDEPTH)) u_escaped (
        .i_clk   (i_clk),
        .i_we    (dec_go && c_ew_en),
        .i_waddr (c_ew_addr),
        .i_wdata (c_ew_data),
        .i_re    (r_state == S_MRD),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_active <= LANE_MASK;
            r_depth  <= '0;
            r_mi     <= '0;
            for (int k = 0; k < BARRIER_REGS; k++) begin
                r_valid[k] <= 1'b0;
                r_frel[k]  <= 1'b0;
                r_ftgt[k]  <= '0;
                r_fpart[k] <= '0;
                r_farr[k]  <= '0;
                r_pcnt[k]  <= '0;
                r_ecnt[k]  <= '0;
            end
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_kind  <= i_s_axis_tuser[1:0];
                        r_rel   <= i_s_axis_tuser[2];
                        r_idx   <= i_s_axis_tdata[3:0];
                        r_tgt   <= i_s_axis_tdata[35:4];
                        r_ipc   <= i_s_axis_tdata[67:36];
                        r_guard <= i_s_axis_tdata[99:68] & LANE_MASK;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (out_free) begin
                        r_active <= n_active;
                        r_valid  <= n_valid;
                        r_frel   <= n_frel;
                        r_ftgt   <= n_ftgt;
                        r_fpart  <= n_fpart;
                        r_farr   <= n_farr;
                        r_pcnt   <= n_pcnt;
                        r_ecnt   <= n_ecnt;
                        r_stack  <= n_stack;
                        r_depth  <= n_depth;
                        r_res_pc <= c_pc;
                        case (c_op)
                            OP_RESUME: r_state <= S_RES;
                            OP_MOVE: begin
                                r_mv_src  <= c_mv_src;
                                r_mv_dst  <= c_mv_dst;
                                r_mv_base <= c_mv_base;
                                r_mv_cnt  <= c_mv_cnt;
                                r_mi      <= '0;
                                r_state   <= S_MRD;
                            end
                            default: begin
                                r_odata  <= {5'd0, n_active, c_pc, c_st};
                                r_state  <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_active <= 32'(p_rdata[WARP_LANES-1:0]);
                        r_odata  <= {5'd0, 32'(p_rdata[WARP_LANES-1:0]),
                                     p_rdata[MW-1:WARP_LANES], ST_OK};
                        r_state  <= S_IDLE;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    if (r_mi == r_mv_cnt - CW'(1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_mi    <= r_mi + CW'(1);
                        r_state <= S_MRD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_odata  <= {5'd0, r_active, r_res_pc, ST_OK};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The open stack never grows past the number of barrier registers.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= BARRIER_REGS)
        else $error("open depth out of range");

    // A path move never reads beyond the escaped list it copies.
    a_move_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRD || r_state == S_MWR) |-> (r_mi < r_mv_cnt))
        else $error("path move index past count");

    // A resume follows the decide step that issued the RAM read.
    a_resume_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> ($past(r_state) == S_DEC || $past(r_state) == S_RES))
        else $error("resume without a read");

    // The innermost open frame is valid and its pending count is in range.
    a_top_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (r_valid[r_stack[BW'(r_depth - DW'(1))]] &&
            32'(r_pcnt[r_stack[BW'(r_depth - DW'(1))]]) <= PATHS_PER_FRAME))
        else $error("innermost frame inconsistent");

endmodule
`default_nettype wire
